// ===== rtl/bitonic_sorter_macros.svh =====
// assertion macros for the bitonic sorter checker
`ifndef BITONIC_SORTER_MACROS_SVH
`define BITONIC_SORTER_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define BS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on the rising clock edge outside reset
`define BS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bs_pkg.sv =====
// shared types and constants of the bitonic sorter
`default_nettype none

package bs_pkg;

	localparam int VALUE_W = 32;
	localparam int LG_W    = 3;

	localparam logic [LG_W-1:0] LENGTH_LOG2_RESET = 3'd6;

	typedef logic signed [VALUE_W-1:0] value_t;

	// one loaded value as the front hands it to the back
	typedef struct packed {
		value_t            value;
		logic [LG_W-1:0]   lg;
		logic              is_final;
	} entry_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_WR1,
		BK_WR2,
		BK_EMIT
	} back_state_t;

endpackage

`default_nettype wire

// ===== rtl/bs_front.sv =====
// front end: takes values in, picks their store position and marks batch ends
`default_nettype none

module bs_front #(
	parameter int MAX_LENGTH = 64
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 accept,
	input  wire bs_pkg::value_t                       value,
	input  wire logic [bs_pkg::LG_W-1:0]              length_log2,
	output logic [((MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1)-1:0] push_pos,
	output bs_pkg::entry_t                            push_entry
);

	localparam int AW     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int LG_MAX = $clog2(MAX_LENGTH + 1) - 1;

	logic [AW-1:0]             count_q;
	logic [bs_pkg::LG_W-1:0]   lg_eff;
	logic [AW:0]               n_full;
	logic [AW-1:0]             n_mask;
	logic [AW-1:0]             pos;
	logic                      is_final;

	// clamp the length to at least two and at most the store size
	always_comb begin
		lg_eff = length_log2;
		if (length_log2 == '0) begin
			lg_eff = bs_pkg::LG_W'(1);
		end else if (length_log2 > bs_pkg::LG_W'(LG_MAX)) begin
			lg_eff = bs_pkg::LG_W'(LG_MAX);
		end
		n_full   = ((AW + 1)'(1) << lg_eff) - (AW + 1)'(1);
		n_mask   = n_full[AW-1:0];
		pos      = (count_q > n_mask) ? n_mask : count_q;
		is_final = (pos == n_mask);
	end

	assign push_pos            = pos;
	assign push_entry.value    = value;
	assign push_entry.lg       = lg_eff;
	assign push_entry.is_final = is_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= is_final ? '0 : pos + AW'(1);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bs_queue.sv =====
// two-entry queue between the front end and the sort engine
`default_nettype none

module bs_queue #(
	parameter int WIDTH = 42
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic                  full,
	output logic                  not_empty,
	output logic [WIDTH-1:0]      head
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bs_back.sv =====
// sort engine: value store, compare-exchange sequencer and result emission
`default_nettype none

module bs_back #(
	parameter int MAX_LENGTH = 64
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 q_valid,
	input  wire logic [((MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1)-1:0] q_pos,
	input  wire bs_pkg::entry_t                       q_entry,
	output logic                                      q_pop,
	output logic                                      result_valid,
	output bs_pkg::value_t                            sorted_value,
	output logic                                      last
);

	localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

	bs_pkg::back_state_t       state_q, state_d;

	bs_pkg::value_t            mem [MAX_LENGTH];
	bs_pkg::value_t            rd_a_q, rd_b_q;

	logic [bs_pkg::LG_W-1:0]   lg_q, kl_q, jl_q;
	logic [AW-1:0]             t_q, e_q;
	logic [AW-1:0]             i_q, p_q;
	logic                      up_q, stage_end_q, done_q;
	logic                      out_v_s1, out_last_s1;

	logic [AW:0]               n_full, half_full;
	logic [AW-1:0]             n_mask, half_mask;
	logic [3:0]                jl_p1;
	logic [AW-1:0]             low_mask, i_c, p_c, k_sh;
	logic                      up_c, stage_end_c, last_pair_c, swap;

	logic                      rd_en, we, issue, emit_rd;
	logic [AW-1:0]             addr_a, addr_b, waddr;
	bs_pkg::value_t            wdata;

	// batch size masks and the pair addressed by the counters
	always_comb begin
		n_full      = ((AW + 1)'(1) << lg_q) - (AW + 1)'(1);
		half_full   = ((AW + 1)'(1) << (lg_q - bs_pkg::LG_W'(1))) - (AW + 1)'(1);
		n_mask      = n_full[AW-1:0];
		half_mask   = half_full[AW-1:0];
		jl_p1       = {1'b0, jl_q} + 4'd1;
		low_mask    = (AW'(1) << jl_q) - AW'(1);
		i_c         = ((t_q >> jl_q) << jl_p1) | (t_q & low_mask);
		p_c         = i_c | (AW'(1) << jl_q);
		k_sh        = i_c >> kl_q;
		up_c        = ~k_sh[0];
		stage_end_c = (t_q == half_mask);
		last_pair_c = stage_end_c && (jl_q == '0) && (kl_q == lg_q);
		swap        = up_q ? (rd_a_q > rd_b_q) : (rd_b_q > rd_a_q);
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		rd_en   = 1'b0;
		issue   = 1'b0;
		emit_rd = 1'b0;
		we      = 1'b0;
		addr_a  = i_c;
		addr_b  = p_c;
		waddr   = i_q;
		wdata   = swap ? rd_b_q : rd_a_q;
		case (state_q)
			bs_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					we    = 1'b1;
					waddr = q_pos;
					wdata = q_entry.value;
					if (q_entry.is_final) begin
						state_d = bs_pkg::BK_READ;
					end
				end
			end
			bs_pkg::BK_READ: begin
				rd_en   = 1'b1;
				issue   = 1'b1;
				state_d = bs_pkg::BK_WR1;
			end
			bs_pkg::BK_WR1: begin
				we      = 1'b1;
				state_d = bs_pkg::BK_WR2;
			end
			bs_pkg::BK_WR2: begin
				// second write of the pair; next pair of the same stage is read alongside
				we    = 1'b1;
				waddr = p_q;
				wdata = swap ? rd_a_q : rd_b_q;
				if (done_q) begin
					state_d = bs_pkg::BK_EMIT;
				end else if (stage_end_q) begin
					state_d = bs_pkg::BK_READ;
				end else begin
					rd_en   = 1'b1;
					issue   = 1'b1;
					state_d = bs_pkg::BK_WR1;
				end
			end
			bs_pkg::BK_EMIT: begin
				rd_en   = 1'b1;
				emit_rd = 1'b1;
				addr_a  = e_q;
				if (e_q == n_mask) begin
					state_d = bs_pkg::BK_IDLE;
				end
			end
			default: state_d = bs_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bs_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_a_q <= mem[addr_a];
			rd_b_q <= mem[addr_b];
		end
	end

	// pair counters: t walks pairs, jl the merge distance, kl the block size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q        <= bs_pkg::LG_W'(1);
			kl_q        <= bs_pkg::LG_W'(1);
			jl_q        <= '0;
			t_q         <= '0;
			e_q         <= '0;
			i_q         <= '0;
			p_q         <= '0;
			up_q        <= 1'b1;
			stage_end_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (q_pop && q_entry.is_final) begin
				lg_q <= q_entry.lg;
				kl_q <= bs_pkg::LG_W'(1);
				jl_q <= '0;
				t_q  <= '0;
				e_q  <= '0;
			end
			if (issue) begin
				i_q         <= i_c;
				p_q         <= p_c;
				up_q        <= up_c;
				stage_end_q <= stage_end_c;
				done_q      <= last_pair_c;
				if (!stage_end_c) begin
					t_q <= t_q + AW'(1);
				end else begin
					t_q <= '0;
					if (jl_q != '0) begin
						jl_q <= jl_q - bs_pkg::LG_W'(1);
					end else begin
						kl_q <= kl_q + bs_pkg::LG_W'(1);
						jl_q <= kl_q;
					end
				end
			end
			if (emit_rd) begin
				e_q <= e_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s1    <= 1'b0;
			out_last_s1 <= 1'b0;
		end else begin
			out_v_s1    <= emit_rd;
			out_last_s1 <= emit_rd && (e_q == n_mask);
		end
	end

	assign result_valid = out_v_s1;
	assign last         = out_last_s1;
	assign sorted_value = rd_a_q;

endmodule

`default_nettype wire

// ===== rtl/bitonic_sorter.sv =====
// bitonic sorter top level: config register, front end, queue and sort engine
//
// Values enter one per transfer on start/value, accepted when start is high
// and busy is low. A batch holds 2^length_log2 values (length_log2 clamped to
// 1..log2(MAX_LENGTH)); the front end steers each value to its slot and tags
// the one that closes the batch. A two-entry queue sits between the front end
// and the sort engine, so up to two values can load while the engine works;
// busy is high only when that queue is full.
// Once the closing value reaches the engine it runs the bitonic network over
// the batch with one compare-exchange unit on a store that has one write port:
// each pair is read, then written back in two writes, the next pair's read
// riding on the second write, and each of the L(L+1)/2 stages opens with its
// own read. Loading runs at one value per cycle while busy is low.
// Results appear on result_valid/sorted_value/last, one per cycle, smallest
// first, last marking the largest; the receiver cannot stall them.
// The length register is written over cfg_valid/cfg_ready/cfg_data and must
// only change while no batch is in flight. Reset empties the queue, clears
// the load position and sets length_log2 to 6; store contents are not cleared.
`default_nettype none

module bitonic_sorter #(
	parameter int MAX_LENGTH = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [31:0]           value,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [bs_pkg::LG_W-1:0]      cfg_data,
	output logic                              result_valid,
	output logic signed [31:0]                sorted_value,
	output logic                              last
);

	localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int QW = AW + $bits(bs_pkg::entry_t);

	logic [bs_pkg::LG_W-1:0] length_log2_q;
	logic                    accept;
	logic [AW-1:0]           push_pos;
	bs_pkg::entry_t          push_entry;
	logic                    q_full, q_not_empty, q_pop;
	logic [QW-1:0]           q_head;
	logic [AW-1:0]           q_pos;
	bs_pkg::entry_t          q_entry;

	assign cfg_ready = 1'b1;
	assign accept    = start && !q_full;
	assign busy      = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_log2_q <= bs_pkg::LENGTH_LOG2_RESET;
		end else if (cfg_valid && cfg_ready) begin
			length_log2_q <= cfg_data;
		end
	end

	bs_front #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.value       (value),
		.length_log2 (length_log2_q),
		.push_pos    (push_pos),
		.push_entry  (push_entry)
	);

	bs_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data ({push_pos, push_entry}),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	assign q_pos   = q_head[QW-1 -: AW];
	assign q_entry = q_head[$bits(bs_pkg::entry_t)-1:0];

	bs_back #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_not_empty),
		.q_pos        (q_pos),
		.q_entry      (q_entry),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.sorted_value (sorted_value),
		.last         (last)
	);

endmodule

`default_nettype wire

// ===== rtl/bs_checker.sv =====
// port-level checks on the result stream of the bitonic sorter
`default_nettype none

`include "bitonic_sorter_macros.svh"

module bs_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               result_valid,
	input  wire logic signed [31:0] sorted_value,
	input  wire logic               last
);

	`BS_ASSERT_NOW(a_last_has_strobe, last, result_valid, "last without a result transfer")
	`BS_ASSERT_NEXT(a_burst_unbroken, result_valid && !last, result_valid, "gap inside a batch")
	`BS_ASSERT_NEXT(a_burst_closed, result_valid && last, !result_valid, "result right after last")
	`BS_ASSERT_NEXT(a_ascending, result_valid && !last, sorted_value >= $past(sorted_value), "descending results")

endmodule

bind bitonic_sorter bs_checker u_bs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.sorted_value (sorted_value),
	.last         (last)
);

`default_nettype wire

// ===== tb/tb_bitonic_sorter.sv =====
// testbench for the bitonic sorter: batch loads, length changes, sorted output checks
module tb_bitonic_sorter;

	localparam int MAX_LENGTH     = 64;
	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 11;
	localparam int TOTAL_ITEMS    = 260;
	// past this many values the sender stops idling
	localparam int CALM_ITEMS     = 200;
	// queue drain of loaded values that close no batch
	localparam int SETTLE_CYCLES  = 64;
	localparam int TAIL_CYCLES    = 100;
	// the limit outlasts a full 64-value sort, which gives no result while it runs
	localparam int WATCHDOG_LIMIT = 20000;

	localparam bs_pkg::value_t VALUE_MAX = bs_pkg::value_t'(32'h7fff_ffff);
	localparam bs_pkg::value_t VALUE_MIN = bs_pkg::value_t'(32'h8000_0000);

	typedef struct packed {
		bs_pkg::value_t value;
		logic           last;
	} sorted_item_t;

	class sorted_batch_board;
		bs_pkg::value_t          store [MAX_LENGTH];
		int unsigned             fill;
		logic [bs_pkg::LG_W-1:0] length_log2;
		sorted_item_t            pending [$];
		int unsigned             mismatches;

		function new();
			fill = 0;
			length_log2 = bs_pkg::LENGTH_LOG2_RESET;
			mismatches = 0;
		endfunction

		static function int unsigned length_of(logic [bs_pkg::LG_W-1:0] lg);
			int unsigned n;
			n = (lg < 1) ? 2 : (1 << lg);
			if (n > MAX_LENGTH) begin
				n = MAX_LENGTH;
			end
			return n;
		endfunction

		function void set_length(logic [bs_pkg::LG_W-1:0] lg);
			length_log2 = lg;
		endfunction

		function void bitonic_pass(int unsigned n);
			int unsigned k, j, i, p;
			bs_pkg::value_t a, b;
			logic up;
			for (k = 2; k <= n; k = k << 1) begin
				for (j = k >> 1; j > 0; j = j >> 1) begin
					for (i = 0; i < n; i++) begin
						p = i ^ j;
						if (p > i && p < n) begin
							up = ((i & k) == 0);
							a = store[i];
							b = store[p];
							if (up ? (a > b) : (b > a)) begin
								store[i] = b;
								store[p] = a;
							end
						end
					end
				end
			end
		endfunction

		// one accepted value; the value that closes a batch queues the sorted batch
		function void load_value(bs_pkg::value_t v);
			int unsigned n, pos, i;
			sorted_item_t item;
			n = length_of(length_log2);
			// a length lowered mid-batch pins the write position to the top slot
			pos = (fill > n - 1) ? n - 1 : fill;
			store[pos] = v;
			if (pos < n - 1) begin
				fill = pos + 1;
				return;
			end
			bitonic_pass(n);
			for (i = 0; i < n; i++) begin
				item.value = store[i];
				item.last = (i == n - 1);
				pending.push_back(item);
			end
			fill = 0;
		endfunction

		task report(string msg);
			$display("%0t: mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(bs_pkg::value_t v, logic l);
			sorted_item_t exp_item;
			if (pending.size() == 0) begin
				report($sformatf("sorted value %0d arrived with none pending", v));
				return;
			end
			exp_item = pending.pop_front();
			if (v !== exp_item.value) begin
				report($sformatf("sorted_value %0d, predicted %0d", v, exp_item.value));
			end
			if (l !== exp_item.last) begin
				report($sformatf("last %b on value %0d, predicted %b", l, v, exp_item.last));
			end
		endtask
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	bs_pkg::value_t          value = '0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [bs_pkg::LG_W-1:0] cfg_data = '0;
	logic                    result_valid;
	bs_pkg::value_t          sorted_value;
	logic                    last;

	sorted_batch_board sb = new();
	int unsigned items_sent = 0;
	int unsigned quiet_cycles = 0;

	bitonic_sorter #(
		.MAX_LENGTH(MAX_LENGTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.sorted_value(sorted_value),
		.last(last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid) begin
				sb.check_result(sorted_value, last);
			end
			if (start && !busy) begin
				sb.load_value(value);
			end
			if (cfg_valid && cfg_ready) begin
				sb.set_length(cfg_data);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || (cfg_valid && cfg_ready) || result_valid) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic bs_pkg::value_t rand_value();
		case ($urandom_range(0, 7))
			0: return VALUE_MIN;
			1: return VALUE_MAX;
			// narrow range near zero gives plenty of equal keys
			2: return bs_pkg::value_t'($urandom_range(0, 6)) - 3;
			default: return bs_pkg::value_t'($urandom);
		endcase
	endfunction

	task automatic send_value(input bs_pkg::value_t v);
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		items_sent++;
		if (items_sent < CALM_ITEMS && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// the first wait lets the last transfer reach the scoreboard
	task automatic drain_sorted();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// length changes only once every predicted sorted value has arrived; an open batch may remain
	task automatic write_length(input logic [bs_pkg::LG_W-1:0] lg);
		drain_sorted();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= lg;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned phase, n, batches;
		logic [bs_pkg::LG_W-1:0] lg;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// smallest batches at the value extremes, length zero clamps to two
		write_length(3'd1);
		send_value(VALUE_MAX);
		send_value(VALUE_MIN);
		write_length(3'd0);
		send_value('0);
		send_value(-1);
		// length raised mid-batch: loading carries on to the new size
		write_length(3'd2);
		send_value(VALUE_MIN);
		send_value(VALUE_MAX);
		write_length(3'd3);
		send_value(-1);
		send_value(1);
		send_value('0);
		send_value(VALUE_MIN + 1);
		send_value(VALUE_MAX - 1);
		send_value('0);
		// oversized length, then lowered mid-batch below the fill level
		write_length(3'd7);
		send_value(VALUE_MAX);
		send_value(-1);
		send_value(VALUE_MIN);
		send_value(7);
		send_value('0);
		write_length(3'd1);
		send_value(3);

		phase = 0;
		while (items_sent < TOTAL_ITEMS) begin
			if (phase == 2) begin
				lg = 3'd6;
			end else if ($urandom_range(0, 7) == 0) begin
				lg = 3'd5;
			end else begin
				lg = bs_pkg::LG_W'($urandom_range(0, 4));
			end
			write_length(lg);
			n = sorted_batch_board::length_of(lg);
			batches = (lg >= 5) ? 1 : $urandom_range(1, 4);
			repeat (batches) begin
				repeat (n) send_value(rand_value());
				if ($urandom_range(0, 9) == 0) begin
					drain_sorted();
				end
			end
			// sometimes leave a batch open across the next length change
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 3)) send_value(rand_value());
			end
			phase++;
		end

		drain_sorted();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending.size() != 0) begin
			sb.report($sformatf("%0d sorted values never arrived", sb.pending.size()));
		end
		if (sb.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
